>>> rtl/core/wear_leveled_value_ring_unit_macros.svh
// assertion macros for the wear leveled value ring unit
`ifndef WEAR_LEVELED_VALUE_RING_UNIT_MACROS_SVH
`define WEAR_LEVELED_VALUE_RING_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same cycle implication
`define WLVR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same cycle implication");

// next cycle implication
`define WLVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle implication");

`else

`define WLVR_ASSERT_NOW(label, clk, rst, ante, cons)
`define WLVR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/wlvr_pkg.sv
// shared types and constants of the wear leveled value ring unit
`default_nettype none

package wlvr_pkg;

   localparam int RING_LEN     = 8;
   localparam int NUM_CHANNELS = 3;
   localparam int STORE_DEPTH  = RING_LEN * NUM_CHANNELS;
   localparam int IDX_W        = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
   localparam int CNT_W        = $clog2(RING_LEN + 1);
   localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int DATA_W       = 8;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_INIT  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  channel;
      logic [7:0]  value;
   } req_type;

   typedef struct packed {
      logic [7:0]  stored_value;
      logic        holds_value;
      logic [2:0]  slot;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_INIT,
      ST_SCAN,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load_req;
      logic scan_clear;
      logic init_store;
      logic scan_run;
      logic update;
      logic respond;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   ch_ok;
      logic   scan_done;
   } stat_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] ch,
                                                   input logic [IDX_W-1:0] idx);
      logic [ADDR_W+2:0] full;
      full = (ADDR_W+3)'(ch) * (ADDR_W+3)'(RING_LEN) + (ADDR_W+3)'(idx);
      return full[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/wlvr_ram.sv
// generic single port write, registered read ram
`default_nettype none

module wlvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 24
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/core/wlvr_datapath.sv
// slot store, scan pipeline and result register
`default_nettype none

module wlvr_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wlvr_pkg::req_type req_word,
   input  wire wlvr_pkg::cmd_type cmd,
   output wlvr_pkg::stat_type     status,
   output logic                   rsp_strobe,
   output wlvr_pkg::rsp_type      rsp_word
);

   wlvr_pkg::req_type                   req_ff, req_in;
   logic [wlvr_pkg::STORE_DEPTH-1:0]    occ_ff, occ_in;
   logic                                marked_ff, marked_in;
   logic [wlvr_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic                                chk_vld_ff, chk_vld_in;
   logic [wlvr_pkg::IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic                                chk_occ_ff, chk_occ_in;
   logic                                found_ff, found_in;
   logic [wlvr_pkg::IDX_W-1:0]          found_idx_ff, found_idx_in;
   logic [7:0]                          found_val_ff, found_val_in;
   logic                                strobe_ff, strobe_in;
   wlvr_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                                ch_ok;
   logic                                issue;
   logic [wlvr_pkg::ADDR_W-1:0]         rd_addr;
   logic [wlvr_pkg::DATA_W-1:0]         rd_data;
   logic [wlvr_pkg::IDX_W-1:0]          tgt_idx, clr_idx;
   logic [wlvr_pkg::ADDR_W-1:0]         tgt_addr, clr_addr;
   logic                                val_nz;

   assign ch_ok  = int'(req_ff.channel) < wlvr_pkg::NUM_CHANNELS;
   assign issue  = cmd.scan_run && (idx_ff < wlvr_pkg::CNT_W'(wlvr_pkg::RING_LEN));
   assign rd_addr = wlvr_pkg::slot_addr(req_ff.channel, idx_ff[wlvr_pkg::IDX_W-1:0]);
   assign val_nz = req_ff.value != 8'd0;

   // first nonzero slot below the last one moves forward, else wrap to slot 0
   always_comb begin
      if (found_ff && (found_idx_ff != wlvr_pkg::IDX_W'(wlvr_pkg::RING_LEN - 1))) begin
         tgt_idx = found_idx_ff + wlvr_pkg::IDX_W'(1);
         clr_idx = found_idx_ff;
      end else begin
         tgt_idx = '0;
         clr_idx = wlvr_pkg::IDX_W'(wlvr_pkg::RING_LEN - 1);
      end
   end

   assign tgt_addr = wlvr_pkg::slot_addr(req_ff.channel, tgt_idx);
   assign clr_addr = wlvr_pkg::slot_addr(req_ff.channel, clr_idx);

   wlvr_ram #(
      .WIDTH (wlvr_pkg::DATA_W),
      .DEPTH (wlvr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (tgt_addr),
      .wr_data (req_ff.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      req_in       = cmd.load_req ? req_word : req_ff;
      occ_in       = occ_ff;
      marked_in    = marked_ff;
      idx_in       = idx_ff;
      chk_vld_in   = issue;
      chk_idx_in   = idx_ff[wlvr_pkg::IDX_W-1:0];
      chk_occ_in   = occ_ff[rd_addr];
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_val_in = found_val_ff;
      strobe_in    = cmd.respond;
      rsp_in       = rsp_ff;

      if (cmd.init_store && !marked_ff) begin
         occ_in    = '0;
         marked_in = 1'b1;
      end
      if (cmd.update) begin
         occ_in[clr_addr] = 1'b0;
         occ_in[tgt_addr] = val_nz;
      end

      if (cmd.scan_clear) begin
         idx_in       = '0;
         found_in     = 1'b0;
         found_idx_in = '0;
         found_val_in = 8'd0;
      end else begin
         if (issue) begin
            idx_in = idx_ff + wlvr_pkg::CNT_W'(1);
         end
         // a slot whose occupied bit is clear reads as zero
         if (chk_vld_ff && !found_ff && chk_occ_ff && (rd_data != 8'd0)) begin
            found_in     = 1'b1;
            found_idx_in = chk_idx_ff;
            found_val_in = rd_data;
         end
      end

      if (cmd.respond) begin
         if (!ch_ok) begin
            rsp_in = '0;
         end else if (req_ff.op == wlvr_pkg::OP_WRITE) begin
            rsp_in.stored_value = req_ff.value;
            rsp_in.holds_value  = val_nz;
            rsp_in.slot         = val_nz ? 3'(tgt_idx) : 3'd0;
         end else begin
            rsp_in.stored_value = found_val_ff;
            rsp_in.holds_value  = found_ff;
            rsp_in.slot         = 3'(found_idx_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         marked_ff    <= 1'b0;
         idx_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         found_idx_ff <= '0;
         found_val_ff <= 8'd0;
         strobe_ff    <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         marked_ff    <= marked_in;
         idx_ff       <= idx_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         found_idx_ff <= found_idx_in;
         found_val_ff <= found_val_in;
         strobe_ff    <= strobe_in;
      end
      req_ff     <= req_in;
      chk_idx_ff <= chk_idx_in;
      chk_occ_ff <= chk_occ_in;
      rsp_ff     <= rsp_in;
   end

   assign status.op        = req_ff.op;
   assign status.ch_ok     = ch_ok;
   assign status.scan_done = (idx_ff == wlvr_pkg::CNT_W'(wlvr_pkg::RING_LEN)) && !chk_vld_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_word         = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/core/wlvr_ctrl.sv
// sequencing state machine of the wear leveled value ring unit
`default_nettype none

module wlvr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire wlvr_pkg::stat_type status,
   output wlvr_pkg::cmd_type       cmd,
   output logic                    busy
);

   wlvr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wlvr_pkg::ST_IDLE: begin
            if (start) begin
               state_in = wlvr_pkg::ST_SETUP;
            end
         end
         wlvr_pkg::ST_SETUP: begin
            if (status.op == wlvr_pkg::OP_INIT) begin
               state_in = wlvr_pkg::ST_INIT;
            end else if (status.ch_ok) begin
               state_in = wlvr_pkg::ST_SCAN;
            end else begin
               state_in = wlvr_pkg::ST_RESPOND;
            end
         end
         wlvr_pkg::ST_INIT: begin
            state_in = status.ch_ok ? wlvr_pkg::ST_SCAN : wlvr_pkg::ST_RESPOND;
         end
         wlvr_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = (status.op == wlvr_pkg::OP_WRITE) ? wlvr_pkg::ST_UPDATE
                                                            : wlvr_pkg::ST_RESPOND;
            end
         end
         wlvr_pkg::ST_UPDATE: begin
            state_in = wlvr_pkg::ST_RESPOND;
         end
         wlvr_pkg::ST_RESPOND: begin
            state_in = wlvr_pkg::ST_IDLE;
         end
         default: begin
            state_in = wlvr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         wlvr_pkg::ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         wlvr_pkg::ST_SETUP: begin
            cmd.scan_clear = 1'b1;
         end
         wlvr_pkg::ST_INIT: begin
            cmd.init_store = 1'b1;
         end
         wlvr_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         wlvr_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         wlvr_pkg::ST_RESPOND: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wlvr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/wear_leveled_value_ring_unit.sv
// read and op 3 pass setup, scan and respond; a write adds update after the scan,
// init adds init before it; on an absent channel setup, or init for init, goes straight to respond
// no new word until the last is done; the slot scan reads the store ram one slot a cycle
// busy is low again in the strobe cycle, so the next word may start then
// the receiver cannot stall: each result shows for exactly one cycle
// reset empties every ring at once through per slot occupied bits and clears the marker
`default_nettype none

`include "wear_leveled_value_ring_unit_macros.svh"

module wear_leveled_value_ring_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire wlvr_pkg::req_type req_word,
   output logic                   rsp_strobe,
   output wlvr_pkg::rsp_type      rsp_word
);

   wlvr_pkg::cmd_type  cmd;
   wlvr_pkg::stat_type status;

   wlvr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   wlvr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   `WLVR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `WLVR_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `WLVR_ASSERT_NOW(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   `WLVR_ASSERT_NOW(a_empty_zero, clock, reset, rsp_strobe && !rsp_word.holds_value,
      (rsp_word.stored_value == 8'd0) && (rsp_word.slot == 3'd0))

endmodule

`default_nettype wire
